// ===== rtl/pawg_pkg.sv =====
// Shared types and constants for the page-aligned window geometry block.
package pawg_pkg;

  localparam int unsigned W = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned ADDR_WIDTH_DEF = 64;

  localparam logic [W-1:0] PAGE_BYTES_RST = 64'd4096;
  localparam logic [W-1:0] MAX_WINDOW_RST = 64'd1073741824;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_BYTES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW = 8'd1;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_PAGE = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_PAST_EOF = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // one slot of the remainder chain
  typedef struct packed {
    logic         valid;
    logic [2:0]   status;
    logic [W-1:0] off;
    logic [W-1:0] eff;
    logic [W-1:0] rem_off;
    logic [W-1:0] rem_eff;
  } stage_t;

endpackage

// ===== rtl/pawg_if.sv =====
// Channel interfaces: request, result and configuration write.
interface pawg_req_if;
  logic                   valid;
  logic                   ready;
  logic [pawg_pkg::W-1:0] window_offset;
  logic [pawg_pkg::W-1:0] window_length;
  logic [pawg_pkg::W-1:0] file_bytes;
  modport source (output valid, window_offset, window_length, file_bytes, input ready);
  modport sink (input valid, window_offset, window_length, file_bytes, output ready);
endinterface

interface pawg_res_if;
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [pawg_pkg::W-1:0] map_offset;
  logic [pawg_pkg::W-1:0] map_length;
  logic [pawg_pkg::W-1:0] slop;
  logic [pawg_pkg::W-1:0] effective_length;
  modport source (output valid, status, map_offset, map_length, slop, effective_length,
                  input ready);
  modport sink (input valid, status, map_offset, map_length, slop, effective_length,
                output ready);
endinterface

interface pawg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pawg_pkg::CFG_IDX_W-1:0] index;
  logic [pawg_pkg::W-1:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pawg_cell.sv =====
// One restoring remainder step on both dividends, one dividend bit per cell.
module pawg_cell #(
  parameter int unsigned BIT = 63
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [pawg_pkg::W-1:0] page_bytes,
  input  pawg_pkg::stage_t       din,
  output pawg_pkg::stage_t       dout
);

  logic [pawg_pkg::W:0] sh_off, sh_eff, sub_off, sub_eff;
  pawg_pkg::stage_t     dout_next;

  always_comb begin
    sh_off = {din.rem_off, din.off[BIT]};
    sh_eff = {din.rem_eff, din.eff[BIT]};
    sub_off = sh_off - {1'b0, page_bytes};
    sub_eff = sh_eff - {1'b0, page_bytes};
    dout_next = din;
    dout_next.rem_off = (sh_off >= {1'b0, page_bytes}) ? sub_off[pawg_pkg::W-1:0]
                                                       : sh_off[pawg_pkg::W-1:0];
    dout_next.rem_eff = (sh_eff >= {1'b0, page_bytes}) ? sub_eff[pawg_pkg::W-1:0]
                                                       : sh_eff[pawg_pkg::W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.status  <= dout_next.status;
      dout.off     <= dout_next.off;
      dout.eff     <= dout_next.eff;
      dout.rem_off <= dout_next.rem_off;
      dout.rem_eff <= dout_next.rem_eff;
    end
  end

endmodule

// ===== rtl/page_aligned_window_geometry_top.sv =====
// Top level of the page-aligned window geometry block.
// Takes a window (offset, length) and a file size and returns a status with the page-aligned
// map offset, the map length in whole pages, the in-page slop and the length clamped to end
// of file; all fields are zero on an error. One request beat is taken every cycle while the
// row is not held. The path is one check stage, a row of 64 remainder cells (one dividend
// bit each, both remainders worked side by side) and two rounding stages, the second of
// which is also the output register. The row moves as a whole; it holds while a result
// waits un-taken. Page size need not be a power of two. ADDR_WIDTH below 32 acts as 32 and
// above 64 as 64. Configuration writes are taken at any time, but only while no request is
// in flight do they give defined results.
module page_aligned_window_geometry_top #(
  parameter int unsigned ADDR_WIDTH = pawg_pkg::ADDR_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  pawg_req_if.sink   req,
  pawg_res_if.source res,
  pawg_cfg_if.sink   cfg
);

  localparam int unsigned NC = pawg_pkg::W;
  localparam int unsigned AW = (ADDR_WIDTH < 32) ? 32 :
                               ((ADDR_WIDTH > pawg_pkg::W) ? pawg_pkg::W : ADDR_WIDTH);
  localparam logic [pawg_pkg::W-1:0] LEN_LIMIT = {pawg_pkg::W{1'b1}} >> (pawg_pkg::W - AW);

  logic [pawg_pkg::W-1:0] page_bytes, max_window;
  logic en;
  pawg_pkg::stage_t head;
  pawg_pkg::stage_t chain [0:NC];

  // configuration registers, unknown indexes dropped
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= pawg_pkg::PAGE_BYTES_RST;
      max_window <= pawg_pkg::MAX_WINDOW_RST;
    end else if (cfg.valid) begin
      if (cfg.index == pawg_pkg::REG_PAGE_BYTES) page_bytes <= cfg.data;
      if (cfg.index == pawg_pkg::REG_MAX_WINDOW) max_window <= cfg.data;
    end
  end

  // whole row advances unless a result is stuck at the output
  assign en = !res.valid || res.ready;
  assign req.ready = en;

  // front checks, in status order
  logic [pawg_pkg::W-1:0] avail;
  pawg_pkg::stage_t front_next;
  always_comb begin
    avail = req.file_bytes - req.window_offset;
    front_next = '0;
    front_next.valid = req.valid;
    front_next.off = req.window_offset;
    front_next.eff = (req.window_length < avail) ? req.window_length : avail;
    priority if (page_bytes == '0) front_next.status = pawg_pkg::ST_BAD_PAGE;
    else if (req.window_length == '0) front_next.status = pawg_pkg::ST_EMPTY;
    else if (req.window_length > max_window) front_next.status = pawg_pkg::ST_TOO_LARGE;
    else if (req.window_offset >= req.file_bytes) front_next.status = pawg_pkg::ST_PAST_EOF;
    else front_next.status = pawg_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (en) begin
      head.valid <= front_next.valid;
    end
    if (en) begin
      head.status  <= front_next.status;
      head.off     <= front_next.off;
      head.eff     <= front_next.eff;
      head.rem_off <= '0;
      head.rem_eff <= '0;
    end
  end

  assign chain[0] = head;

  // remainder row, most significant dividend bit first
  for (genvar i = 0; i < NC; i++) begin : g_cell
    pawg_cell #(.BIT(NC - 1 - i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .page_bytes (page_bytes),
      .din        (chain[i]),
      .dout       (chain[i+1])
    );
  end

  // rounding, first stage: need and need mod p from the two remainders, page base
  pawg_pkg::stage_t tail;
  logic [pawg_pkg::W:0] need_next, rn_sum, rn_sub;
  logic [pawg_pkg::W-1:0] rn_next, base_next;
  assign tail = chain[NC];
  always_comb begin
    need_next = {1'b0, tail.rem_off} + {1'b0, tail.eff};
    rn_sum    = {1'b0, tail.rem_off} + {1'b0, tail.rem_eff};
    rn_sub    = rn_sum - {1'b0, page_bytes};
    rn_next   = (rn_sum >= {1'b0, page_bytes}) ? rn_sub[pawg_pkg::W-1:0]
                                               : rn_sum[pawg_pkg::W-1:0];
    base_next = tail.off - tail.rem_off;
  end

  logic                   rnd_valid;
  logic [2:0]             rnd_status;
  logic [pawg_pkg::W:0]   need;
  logic [pawg_pkg::W-1:0] rn, base, rnd_slop, rnd_eff;
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
    end else if (en) begin
      rnd_valid <= tail.valid;
    end
    if (en) begin
      rnd_status <= tail.status;
      need       <= need_next;
      rn         <= rn_next;
      base       <= base_next;
      rnd_slop   <= tail.rem_off;
      rnd_eff    <= tail.eff;
    end
  end

  // rounding, second stage: round need up to pages, overflow checks
  logic [pawg_pkg::W:0] total, mapend;
  logic [2:0] st;
  always_comb begin
    total  = need - {1'b0, rn} + ((rn != '0) ? {1'b0, page_bytes} : '0);
    mapend = {1'b0, base} + {1'b0, total[pawg_pkg::W-1:0]};
    st = rnd_status;
    if (st == pawg_pkg::ST_OK &&
        (need[pawg_pkg::W] || total[pawg_pkg::W] || mapend[pawg_pkg::W] ||
         total[pawg_pkg::W-1:0] > LEN_LIMIT)) begin
      st = pawg_pkg::ST_OVERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= rnd_valid;
    end
    if (en) begin
      res.status           <= st;
      res.map_offset       <= (st == pawg_pkg::ST_OK) ? base : '0;
      res.map_length       <= (st == pawg_pkg::ST_OK) ? total[pawg_pkg::W-1:0] : '0;
      res.slop             <= (st == pawg_pkg::ST_OK) ? rnd_slop : '0;
      res.effective_length <= (st == pawg_pkg::ST_OK) ? rnd_eff : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != pawg_pkg::ST_OK |->
      res.map_offset == '0 && res.map_length == '0 && res.slop == '0 &&
      res.effective_length == '0)
    else $error("error result with nonzero fields");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.status <= pawg_pkg::ST_OVERFLOW)
    else $error("status code out of range");
  a_slop_lt_page: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == pawg_pkg::ST_OK |->
      res.slop < page_bytes && res.map_length >= res.effective_length)
    else $error("ok result with bad geometry");
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !req.ready)
    else $error("request taken while row is stalled");
`endif

endmodule
